[rtl/mprq_pkg.sv]
package mprq_pkg;
   localparam int SlotsDefault  = 64;
   localparam int LevelsDefault = 128;
   localparam int SlotW  = 6;
   localparam int LevelW = 7;
   localparam int DlW    = 64;

   localparam logic [1:0] MODE_BACK   = 2'd0;
   localparam logic [1:0] MODE_FRONT  = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_POP    = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOOP  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage

[rtl/mprq_bitmap.sv]
// level occupancy bitmap with a registered, iterative top-level rescan
module mprq_bitmap import mprq_pkg::*; #(
   parameter int LEVELS = LevelsDefault,
   localparam int LvW = $clog2(LEVELS)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           set_en,
   input  logic           clr_en,
   input  logic [LvW-1:0] lvl,
   input  logic           scan_start,
   output logic           scan_busy,
   output logic           bit_out,
   output logic           top_valid,
   output logic [LvW-1:0] top
);
   logic [LEVELS-1:0] bits_ff;
   logic              busy_ff;
   logic [LvW-1:0]    idx_ff;
   logic              tv_ff;
   logic [LvW-1:0]    top_ff;

   assign bit_out   = bits_ff[lvl];
   assign scan_busy = busy_ff;
   assign top_valid = tv_ff;
   assign top       = top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         busy_ff <= 1'b0;
         tv_ff   <= 1'b0;
         top_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         if (set_en) begin
            bits_ff[lvl] <= 1'b1;
            if (!tv_ff || lvl > top_ff) begin
               tv_ff  <= 1'b1;
               top_ff <= lvl;
            end
         end
         if (clr_en) bits_ff[lvl] <= 1'b0;
         if (scan_start) begin
            busy_ff <= 1'b1;
            tv_ff   <= 1'b0;
            idx_ff  <= top_ff;
         end else if (busy_ff) begin
            // walk downward one level a cycle
            if (bits_ff[idx_ff]) begin
               tv_ff   <= 1'b1;
               top_ff  <= idx_ff;
               busy_ff <= 1'b0;
            end else if (idx_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
      end
   end
endmodule

[rtl/multilevel_priority_run_queue_top.sv]
// Multilevel priority run queue.
// Command channel: drive req_* with start high while busy is low; the item is
// taken at that edge. Modes: enqueue back/front (optionally deadline ordered),
// remove slot, pop front of highest non-empty level.
// Exactly one result per item, shown for one cycle with rsp_valid; the
// receiver cannot stall, so it must capture rsp_* in that cycle.
// Link lists live in single-port-read memories with a registered read port,
// so each read takes an address state and a capture state. A deadline-ordered
// insert into an occupied level walks the entries one by one (S_E_WALK,
// S_E_WALKD) until it meets a later deadline or the tail; a pop/remove that
// empties the highest level waits while the bitmap rescans downward. busy
// stays high throughout and drops in the result cycle, so the next item can
// be taken at the edge ending it.
// Reset clears the queued flags, bitmap, count and top level at once; no
// clearing pass. Link, level, deadline and head/tail memories are not
// cleared; they are only read for queued slots or occupied levels.
// An out-of-range level saturates to LEVELS-1.
module multilevel_priority_run_queue_top import mprq_pkg::*; #(
   parameter int SLOTS  = SlotsDefault,
   parameter int LEVELS = LevelsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [SlotW-1:0]    req_thread_slot,
   input  logic [LevelW-1:0]   req_level,
   input  logic                req_deadline_ordered,
   input  logic [DlW-1:0]      req_deadline,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [SlotW-1:0]    rsp_popped_slot,
   output logic [LevelW-1:0]   rsp_popped_level,
   output logic signed [7:0]   rsp_highest_level,
   output logic [6:0]          rsp_queued_total
);
   localparam int SW  = $clog2(SLOTS);
   localparam int LW  = $clog2(LEVELS);
   localparam int PW  = SW + 1;          // link width incl. nil
   localparam int CW  = $clog2(SLOTS + 1);
   localparam logic [PW-1:0] NIL = PW'(SLOTS);

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_E_RD, S_E_HT, S_E_WALK, S_E_WALKD, S_E_PREV,
      S_E_PREVD, S_E_LINK, S_E_FIX1, S_E_FIX2, S_U_RD, S_U_RDD, S_U_HT,
      S_U_FIXP, S_U_FIXN, S_U_HD, S_U_HDD, S_U_END, S_SCAN, S_RESP
   } state_type;

   // memories
   logic [PW-1:0]  next_mem [SLOTS];
   logic [PW-1:0]  prev_mem [SLOTS];
   logic [LW-1:0]  lvl_mem  [SLOTS];
   logic [DlW-1:0] dl_mem   [SLOTS];
   logic [PW-1:0]  head_mem [LEVELS];
   logic [PW-1:0]  tail_mem [LEVELS];
   logic [SLOTS-1:0] queued_ff;

   logic [SW-1:0]  srd_addr;
   logic [PW-1:0]  next_rd_ff, prev_rd_ff;
   logic [LW-1:0]  lvl_rd_ff;
   logic [DlW-1:0] dl_rd_ff;
   logic [LW-1:0]  lrd_addr;
   logic [PW-1:0]  head_rd_ff, tail_rd_ff;

   state_type      state_ff;
   logic [1:0]     mode_ff;
   logic [SW-1:0]  slot_ff;
   logic           slot_big_ff;
   logic [LW-1:0]  lv_ff;
   logic           ord_ff;
   logic [DlW-1:0] dl_ff;
   logic [PW-1:0]  at_ff, bef_ff, p_ff, n_ff;
   logic [CW-1:0]  count_ff;
   logic [1:0]     status_ff;
   logic [SW-1:0]  pslot_ff;
   logic [LW-1:0]  plevel_ff;
   logic           empty_lv_ff;
   logic           rsp_ff;

   // memory write ports
   logic           nw_en, pw_en, hw_en, tw_en;
   logic [SW-1:0]  nw_addr, pw_addr;
   logic [PW-1:0]  nw_data, pw_data, hw_data, tw_data;

   // bitmap
   logic          bm_set, bm_clr, bm_scan, bm_busy, bm_bit, bm_tv;
   logic [LW-1:0] bm_top;

   mprq_bitmap #(.LEVELS(LEVELS)) u_bitmap (
      .clock, .reset, .set_en(bm_set), .clr_en(bm_clr), .lvl(lv_ff),
      .scan_start(bm_scan), .scan_busy(bm_busy), .bit_out(bm_bit),
      .top_valid(bm_tv), .top(bm_top)
   );

   assign lrd_addr = lv_ff;

   always_ff @(posedge clock) begin
      next_rd_ff <= next_mem[srd_addr];
      prev_rd_ff <= prev_mem[srd_addr];
      lvl_rd_ff  <= lvl_mem[srd_addr];
      dl_rd_ff   <= dl_mem[srd_addr];
      head_rd_ff <= head_mem[lrd_addr];
      tail_rd_ff <= tail_mem[lrd_addr];
      if (nw_en) next_mem[nw_addr] <= nw_data;
      if (pw_en) prev_mem[pw_addr] <= pw_data;
      if (hw_en) head_mem[lv_ff] <= hw_data;
      if (tw_en) tail_mem[lv_ff] <= tw_data;
      if (state_ff == S_E_LINK) begin
         lvl_mem[slot_ff] <= lv_ff;
         dl_mem[slot_ff]  <= dl_ff;
      end
   end

   // combinational write/read control
   always_comb begin
      srd_addr = slot_ff;
      nw_en = 1'b0; pw_en = 1'b0; hw_en = 1'b0; tw_en = 1'b0;
      nw_addr = slot_ff; pw_addr = slot_ff;
      nw_data = at_ff; pw_data = bef_ff; hw_data = NIL; tw_data = NIL;
      bm_set = 1'b0; bm_clr = 1'b0; bm_scan = 1'b0;
      unique case (state_ff)
         S_E_WALK:  srd_addr = at_ff[SW-1:0];
         // keep the walked entry on the read port so its prev link is ready
         S_E_WALKD: srd_addr = at_ff[SW-1:0];
         S_E_PREV:  srd_addr = at_ff[SW-1:0];
         S_E_LINK: begin
            nw_en = 1'b1; pw_en = 1'b1;
            nw_data = at_ff; pw_data = bef_ff;
            bm_set = 1'b1;
         end
         S_E_FIX1: begin
            if (bef_ff == NIL) begin
               hw_en = 1'b1; hw_data = PW'(slot_ff);
            end else begin
               nw_en = 1'b1; nw_addr = bef_ff[SW-1:0]; nw_data = PW'(slot_ff);
            end
         end
         S_E_FIX2: begin
            if (at_ff == NIL) begin
               tw_en = 1'b1; tw_data = PW'(slot_ff);
            end else begin
               pw_en = 1'b1; pw_addr = at_ff[SW-1:0]; pw_data = PW'(slot_ff);
            end
         end
         S_U_FIXP: begin
            if (p_ff != NIL) begin
               nw_en = 1'b1; nw_addr = p_ff[SW-1:0]; nw_data = n_ff;
            end else begin
               hw_en = 1'b1; hw_data = n_ff;
            end
         end
         S_U_FIXN: begin
            if (n_ff != NIL) begin
               pw_en = 1'b1; pw_addr = n_ff[SW-1:0]; pw_data = p_ff;
            end else begin
               tw_en = 1'b1; tw_data = p_ff;
            end
         end
         S_U_END: begin
            if (empty_lv_ff) begin
               bm_clr = 1'b1;
               bm_scan = bm_tv && (bm_top == lv_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         queued_ff <= '0;
         count_ff  <= '0;
         rsp_ff    <= 1'b0;
      end else begin
         rsp_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               mode_ff     <= req_mode;
               slot_ff     <= SW'(req_thread_slot);
               slot_big_ff <= 32'(req_thread_slot) >= 32'(SLOTS);
               lv_ff       <= (32'(req_level) >= 32'(LEVELS)) ?
                              LW'(LEVELS - 1) : LW'(req_level);
               ord_ff      <= req_deadline_ordered;
               dl_ff       <= req_deadline;
               status_ff   <= ST_DONE;
               pslot_ff    <= '0;
               plevel_ff   <= '0;
               state_ff    <= S_DECODE;
            end
            S_DECODE: begin
               if (mode_ff == MODE_BACK || mode_ff == MODE_FRONT) begin
                  if (slot_big_ff || queued_ff[slot_ff]) begin
                     status_ff <= ST_NOOP; state_ff <= S_RESP;
                  end else state_ff <= S_E_RD;
               end else if (mode_ff == MODE_REMOVE) begin
                  if (slot_big_ff || !queued_ff[slot_ff]) begin
                     status_ff <= ST_NOOP; state_ff <= S_RESP;
                  end else state_ff <= S_U_RD;
               end else begin
                  if (count_ff == '0 || !bm_tv) begin
                     status_ff <= ST_EMPTY; state_ff <= S_RESP;
                  end else begin
                     lv_ff    <= bm_top;
                     state_ff <= S_U_HD;
                  end
               end
            end
            // read head/tail of level
            S_E_RD: state_ff <= S_E_HT;
            S_E_HT: begin
               if (!bm_bit || (!ord_ff && mode_ff == MODE_BACK)) begin
                  at_ff  <= NIL;
                  bef_ff <= bm_bit ? tail_rd_ff : NIL;
                  state_ff <= S_E_LINK;
               end else begin
                  at_ff <= head_rd_ff;
                  if (ord_ff) state_ff <= S_E_WALK;
                  else begin
                     bef_ff <= NIL;
                     state_ff <= S_E_LINK;
                  end
               end
            end
            S_E_WALK: state_ff <= (at_ff == NIL) ? S_E_PREV : S_E_WALKD;
            S_E_WALKD: begin
               if (dl_rd_ff <= dl_ff) begin
                  at_ff <= next_rd_ff; state_ff <= S_E_WALK;
               end else state_ff <= S_E_PREVD;
            end
            S_E_PREV: begin
               bef_ff <= tail_rd_ff; state_ff <= S_E_LINK;
            end
            S_E_PREVD: begin
               bef_ff <= prev_rd_ff; state_ff <= S_E_LINK;
            end
            S_E_LINK: begin
               queued_ff[slot_ff] <= 1'b1;
               count_ff <= count_ff + 1'b1;
               state_ff <= S_E_FIX1;
            end
            S_E_FIX1: state_ff <= S_E_FIX2;
            S_E_FIX2: state_ff <= S_RESP;
            // pop: fetch head of top level
            S_U_HD: state_ff <= S_U_HDD;
            S_U_HDD: begin
               slot_ff   <= head_rd_ff[SW-1:0];
               pslot_ff  <= SlotW'(head_rd_ff[SW-1:0]);
               plevel_ff <= LevelW'(lv_ff);
               state_ff  <= S_U_RD;
            end
            S_U_RD: state_ff <= S_U_RDD;
            S_U_RDD: begin
               p_ff  <= prev_rd_ff;
               n_ff  <= next_rd_ff;
               lv_ff <= lvl_rd_ff;
               state_ff <= S_U_HT;
            end
            S_U_HT: state_ff <= S_U_FIXP;
            S_U_FIXP: state_ff <= S_U_FIXN;
            S_U_FIXN: begin
               queued_ff[slot_ff] <= 1'b0;
               if (count_ff != '0) count_ff <= count_ff - 1'b1;
               empty_lv_ff <= (p_ff == NIL) && (n_ff == NIL);
               state_ff <= S_U_END;
            end
            S_U_END: state_ff <= S_SCAN;
            S_SCAN: if (!bm_busy) state_ff <= S_RESP;
            S_RESP: begin
               rsp_ff   <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_ff;
   assign rsp_status        = status_ff;
   assign rsp_popped_slot   = pslot_ff;
   assign rsp_popped_level  = plevel_ff;
   assign rsp_highest_level = bm_tv ? $signed(8'(bm_top)) : -8'sd1;
   assign rsp_queued_total  = 7'(count_ff);
endmodule

[rtl/mprq_checker.sv]
module mprq_checker import mprq_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [1:0]        rsp_status,
   input logic signed [7:0] rsp_highest_level,
   input logic [6:0]        rsp_queued_total
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy during result");
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queued_total == 7'd0 |-> rsp_highest_level == -8'sd1)
      else $error("empty queue with a top level");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_EMPTY) else $error("bad status");
endmodule

bind multilevel_priority_run_queue_top mprq_checker u_mprq_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_status,
   .rsp_highest_level, .rsp_queued_total
);

[tb/multilevel_priority_run_queue_top_tb.sv]
`timescale 1ns / 1ps
module multilevel_priority_run_queue_top_tb;
   import mprq_pkg::*;

   localparam int NSLOT = 64;
   localparam int NLEV  = 128;
   localparam int NIL   = NSLOT;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  slot;
      logic [6:0]  level;
      logic        ordered;
      logic [63:0] deadline;
   } rq_cmd_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [5:0]        pslot;
      logic [6:0]        plevel;
      logic signed [7:0] highest;
      logic [6:0]        total;
   } rq_rsp_type;

   logic clock, reset, start, busy;
   logic [1:0]  req_mode;
   logic [5:0]  req_thread_slot;
   logic [6:0]  req_level;
   logic        req_deadline_ordered;
   logic [63:0] req_deadline;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_popped_slot;
   logic [6:0]  rsp_popped_level;
   logic signed [7:0] rsp_highest_level;
   logic [6:0]  rsp_queued_total;

   multilevel_priority_run_queue_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_thread_slot(req_thread_slot), .req_level(req_level),
      .req_deadline_ordered(req_deadline_ordered), .req_deadline(req_deadline),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_popped_slot(rsp_popped_slot), .rsp_popped_level(rsp_popped_level),
      .rsp_highest_level(rsp_highest_level), .rsp_queued_total(rsp_queued_total)
   );

   // shadow run queue
   bit          q_on[NSLOT];
   int          q_lev[NSLOT];
   logic [63:0] q_dl[NSLOT];
   int          q_nxt[NSLOT], q_prv[NSLOT];
   int          lv_head[NLEV], lv_tail[NLEV];
   bit          lv_busy[NLEV];
   int          q_count = 0;
   int          q_top = -1;

   rq_cmd_type pending_cmds[$];
   rq_rsp_type expected_rsps[$];
   int      errors = 0;
   bit      stim_done = 0;
   int      idle_cycles = 0;

   function automatic void find_top();
      q_top = -1;
      for (int l = NLEV - 1; l >= 0; l--)
         if (lv_busy[l]) begin
            q_top = l;
            return;
         end
   endfunction

   function automatic void insert_before(int s, int lv, int at);
      int prv;
      if (!lv_busy[lv]) begin
         lv_head[lv] = NIL;
         lv_tail[lv] = NIL;
      end
      prv = (at == NIL) ? lv_tail[lv] : q_prv[at];
      q_nxt[s] = at;
      q_prv[s] = prv;
      if (prv == NIL) lv_head[lv] = s; else q_nxt[prv] = s;
      if (at == NIL) lv_tail[lv] = s; else q_prv[at] = s;
      q_on[s] = 1;
      q_lev[s] = lv;
      lv_busy[lv] = 1;
      q_count++;
      if (lv > q_top) q_top = lv;
   endfunction

   function automatic void unlink(int s);
      int lv, p, n;
      lv = q_lev[s];
      p = q_prv[s];
      n = q_nxt[s];
      if (p < NSLOT) q_nxt[p] = n; else lv_head[lv] = n;
      if (n < NSLOT) q_prv[n] = p; else lv_tail[lv] = p;
      q_on[s] = 0;
      q_count--;
      if (lv_head[lv] == NIL) begin
         lv_busy[lv] = 0;
         if (lv == q_top) find_top();
      end
   endfunction

   function automatic rq_rsp_type run_queue_step(rq_cmd_type c);
      rq_rsp_type r;
      int s, lv, at;
      r = '0;
      r.status = ST_DONE;
      s = c.slot;
      lv = c.level;
      if (c.mode == MODE_BACK || c.mode == MODE_FRONT) begin
         if (q_on[s]) r.status = ST_NOOP;
         else begin
            q_dl[s] = c.deadline;
            if (c.ordered) begin
               at = lv_busy[lv] ? lv_head[lv] : NIL;
               while (at < NSLOT && q_dl[at] <= c.deadline) at = q_nxt[at];
            end else if (c.mode == MODE_FRONT) begin
               at = lv_busy[lv] ? lv_head[lv] : NIL;
            end else at = NIL;
            insert_before(s, lv, at);
         end
      end else if (c.mode == MODE_REMOVE) begin
         if (!q_on[s]) r.status = ST_NOOP;
         else unlink(s);
      end else begin
         if (q_count == 0 || q_top < 0) r.status = ST_EMPTY;
         else begin
            r.pslot = 6'(lv_head[q_top]);
            r.plevel = 7'(q_top);
            unlink(lv_head[q_top]);
         end
      end
      r.highest = 8'(q_top);
      r.total = 7'(q_count);
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   function automatic rq_cmd_type make_cmd(logic [1:0] m, int s, int l, bit o,
                                           logic [63:0] d);
      rq_cmd_type c;
      c.mode = m;
      c.slot = 6'(s);
      c.level = 7'(l);
      c.ordered = o;
      c.deadline = d;
      return c;
   endfunction

   function automatic void queue_cmd(rq_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // stimulus
   initial begin
      rq_cmd_type c;
      int hot_lo, p;
      logic [1:0] m;
      // directed
      queue_cmd(make_cmd(MODE_POP, 0, 0, 0, 0));
      queue_cmd(make_cmd(MODE_REMOVE, 5, 0, 1, 0));
      queue_cmd(make_cmd(MODE_BACK, 0, 0, 0, 64'd0));
      queue_cmd(make_cmd(MODE_BACK, 63, 127, 0, '1));
      queue_cmd(make_cmd(MODE_BACK, 63, 3, 0, 0));
      queue_cmd(make_cmd(MODE_FRONT, 1, 127, 0, 64'd7));
      queue_cmd(make_cmd(MODE_BACK, 2, 127, 1, 64'd100));
      queue_cmd(make_cmd(MODE_BACK, 3, 127, 1, 64'd100));
      queue_cmd(make_cmd(MODE_FRONT, 4, 127, 1, 64'd5));
      queue_cmd(make_cmd(MODE_BACK, 5, 127, 1, '1));
      queue_cmd(make_cmd(MODE_BACK, 6, 40, 1, 64'd9));
      queue_cmd(make_cmd(MODE_REMOVE, 3, 0, 0, 0));
      queue_cmd(make_cmd(MODE_REMOVE, 3, 0, 0, 0));
      for (int i = 0; i < 7; i++) queue_cmd(make_cmd(MODE_POP, 0, 0, 1, 0));
      queue_cmd(make_cmd(MODE_REMOVE, 6, 0, 0, 0));
      queue_cmd(make_cmd(MODE_POP, 0, 0, 0, 0));
      // random: clustered slots/levels so queues fill and lists get long
      for (int i = 0; i < 1450; i++) begin
         if (i % 200 == 0) hot_lo = $urandom_range(120);
         p = $urandom_range(99);
         m = (p < 45) ? (p < 30 ? MODE_BACK : MODE_FRONT) : (p < 70 ? MODE_REMOVE : MODE_POP);
         c.mode = m;
         c.slot = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15));
         c.level = 7'(($urandom_range(3) == 0) ? $urandom_range(127)
                                               : hot_lo + $urandom_range(7));
         c.ordered = 1'($urandom_range(1));
         c.deadline = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                               : 64'($urandom_range(20));
         queue_cmd(c);
      end
   end

   // driver
   int gap = 0;
   rq_cmd_type cur;
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_mode <= '0;
         req_thread_slot <= '0;
         req_level <= '0;
         req_deadline_ordered <= 0;
         req_deadline <= '0;
      end else if (start && !busy) begin
         expected_rsps.insert(expected_rsps.size(), run_queue_step(cur));
         gap = gap_len();
         if (gap == 0 && pending_cmds.size() > 0) begin
            cur = pending_cmds[0];
            pending_cmds.delete(0);
            {req_mode, req_thread_slot, req_level, req_deadline_ordered, req_deadline} <= cur;
         end else begin
            start <= 0;
            if (pending_cmds.size() == 0) stim_done = 1;
         end
      end else if (!start) begin
         if (gap > 0) gap--;
         else if (pending_cmds.size() > 0) begin
            cur = pending_cmds[0];
            pending_cmds.delete(0);
            {req_mode, req_thread_slot, req_level, req_deadline_ordered, req_deadline} <= cur;
            start <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rq_rsp_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_popped_slot, rsp_popped_level, rsp_highest_level,
                rsp_queued_total};
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, got);
            errors++;
         end else begin
            want = expected_rsps[0];
            expected_rsps.delete(0);
            if (got.status !== want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            if (got.pslot !== want.pslot)
               $display("%0t: popped_slot exp %0d got %0d", $time, want.pslot, got.pslot);
            if (got.plevel !== want.plevel)
               $display("%0t: popped_level exp %0d got %0d", $time, want.plevel, got.plevel);
            if (got.highest !== want.highest)
               $display("%0t: highest_level exp %0d got %0d", $time, want.highest,
                        got.highest);
            if (got.total !== want.total)
               $display("%0t: queued_total exp %0d got %0d", $time, want.total, got.total);
            if (got !== want) errors++;
         end
      end
   end

   // watchdog on accepted items and results
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;
      fork
         begin
            wait (stim_done && expected_rsps.size() == 0);
            repeat (300) @(posedge clock);
         end
         wait (idle_cycles >= WATCHDOG_LIMIT);
      join_any
      if (idle_cycles < WATCHDOG_LIMIT && errors == 0 && expected_rsps.size() == 0)
         $display("multilevel_priority_run_queue_top_tb: clean");
      else
         $display("multilevel_priority_run_queue_top_tb: errors");
      $finish;
   end
endmodule
